/* hdl/pic_pkg.sv */
`default_nettype none

package pic_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int ID_W        = 32;
    localparam int POS_W       = 16;
    localparam int OUT_CNT_W   = 7;

    typedef enum logic [1:0] {
        FN_INS_FRONT = 2'd0,
        FN_INS_BACK  = 2'd1,
        FN_INS_POS   = 2'd2,
        FN_REMOVE    = 2'd3
    } pic_func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } pic_status_t;

    typedef struct packed {
        pic_func_t          func;
        logic signed [31:0] patient_id;
        logic signed [15:0] position;
    } pic_in_t;

    typedef struct packed {
        pic_status_t        status;
        logic signed [31:0] removed_id;
        logic [6:0]         entry_count;
    } pic_out_t;

    // Control broadcast to every cell in the row.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [CNT_W-1:0] idx;
    } pic_shift_t;

endpackage

`default_nettype wire

/* hdl/positional_insert_queue.sv */
`default_nettype none

// Ordered queue of up to QUEUE_DEPTH ids held in a row of shifting cells.
// An item is given on in_item with start high and is accepted at that clock
// edge; busy stays low, so a new item may be given in every cycle.
// The item inserts an id at the front, at the back or at a 1-based position,
// or removes the front id. The whole row shifts in the same cycle.
// In the cycle after acceptance, done is high for exactly one cycle and result
// carries the status, the removed id and the count held after the item.
// Throughput is one item per cycle, set by the shift of the whole cell row
// in the cycle in which the item is accepted.
// The receiver cannot stall; result holds until the next item is accepted.
// Reset empties the queue and clears done; the cell contents are not cleared
// and are never read before they are written.
module positional_insert_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire pic_pkg::pic_in_t  in_item,
    output logic                   done,
    output pic_pkg::pic_out_t      result
);
    import pic_pkg::*;

    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic             done_reg;
    pic_out_t         result_reg;
    pic_out_t         result_next;
    pic_shift_t       shift;
    logic [ID_W-1:0]  cell_data [QUEUE_DEPTH];
    logic [POS_W-2:0] pos_m1;
    logic [POS_W-2:0] occ_wide;
    logic             pos_bad;
    logic             full;

    assign busy     = 1'b0;
    assign pos_m1   = in_item.position[POS_W-2:0] - (POS_W-1)'(1);
    assign occ_wide = (POS_W-1)'(occ_reg);
    assign pos_bad  = in_item.position[POS_W-1] || (in_item.position == '0);
    assign full     = (occ_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        shift       = '0;
        occ_next    = occ_reg;
        result_next = '0;
        result_next.status = ST_OK;
        case (in_item.func)
            FN_REMOVE:
            begin
                if (occ_reg == '0)
                begin
                    result_next.status = ST_EMPTY;
                end
                else
                begin
                    shift.rem = 1'b1;
                    result_next.removed_id = cell_data[0];
                    occ_next = occ_reg - CNT_W'(1);
                end
            end
            FN_INS_FRONT, FN_INS_BACK, FN_INS_POS:
            begin
                if ((in_item.func == FN_INS_POS) && pos_bad)
                begin
                    result_next.status = ST_BADPOS;
                end
                else if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    shift.ins = 1'b1;
                    occ_next = occ_reg + CNT_W'(1);
                    if (in_item.func == FN_INS_FRONT)
                    begin
                        shift.idx = '0;
                    end
                    else if (in_item.func == FN_INS_BACK)
                    begin
                        shift.idx = occ_reg;
                    end
                    else if (pos_m1 > occ_wide)
                    begin
                        shift.idx = occ_reg;
                    end
                    else
                    begin
                        shift.idx = CNT_W'(pos_m1);
                    end
                end
            end
            default:
            begin
                result_next.status = ST_OK;
            end
        endcase
        if (!start)
        begin
            shift    = '0;
            occ_next = occ_reg;
        end
        result_next.entry_count = OUT_CNT_W'(occ_next);
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic [ID_W-1:0] left_d;
            logic [ID_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = in_item.patient_id;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end
            pic_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .cell_idx   (IDX_W'(gi)),
                .load_data  (in_item.patient_id),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* hdl/pic_cell.sv */
`default_nettype none

module pic_cell (
    input  wire logic                        clk,
    input  wire pic_pkg::pic_shift_t         shift,
    input  wire logic [pic_pkg::IDX_W-1:0]   cell_idx,
    input  wire logic [pic_pkg::ID_W-1:0]    load_data,
    input  wire logic [pic_pkg::ID_W-1:0]    left_data,
    input  wire logic [pic_pkg::ID_W-1:0]    right_data,
    output logic      [pic_pkg::ID_W-1:0]    data
);
    import pic_pkg::*;

    logic [ID_W-1:0]  data_reg;
    logic [ID_W-1:0]  data_next;
    logic [CNT_W-1:0] my_idx;

    assign my_idx = CNT_W'(cell_idx);

    // Entries behind the insert point move one place back; the cell at the
    // insert point takes the new id. A removal moves every entry forward.
    always_comb
    begin
        data_next = data_reg;
        if (shift.rem)
        begin
            data_next = right_data;
        end
        else if (shift.ins)
        begin
            if (my_idx > shift.idx)
            begin
                data_next = left_data;
            end
            else if (my_idx == shift.idx)
            begin
                data_next = load_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire
